FILE: hw/rtl/ant_pkg.sv
// shared types and constants for the aging neighbour table
package ant_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int QUEUE_DEPTH     = 2;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;

  localparam logic [15:0] MAX_AGE_RST    = 16'd64;
  localparam logic [7:0]  NEAR_LIMIT_RST = 8'd50;
  localparam logic [7:0]  DIST_EMPTY     = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_AGE    = 2'd0,
    CFG_NEAR_LIMIT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] max_age;
    logic [7:0]  near_limit;
  } cfg_t;

  typedef struct packed {
    logic        msg_valid;
    logic [7:0]  sender_id;
    logic [7:0]  msg_distance;
    logic [31:0] now;
  } item_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] tick;
    logic [7:0]  distance;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [4:0] neighbour_count;
    logic [7:0] closest_distance;
    logic       too_close;
    logic       dropped;
  } res_t;

endpackage

FILE: hw/rtl/ant_ram.sv
// generic single-port-write, single-port-read ram with registered read
module ant_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/ant_front.sv
// input side: takes beats and holds them in a short queue for the engine
module ant_front
  import ant_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  q_valid,
  input  logic  q_ready,
  output item_t q_item
);

  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  item_t          slots [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] count;
  logic           push;
  logic           pop;

  assign in_ready = (count != QCW'(QUEUE_DEPTH));
  assign q_valid  = (count != '0);
  assign q_item   = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      if (push && !pop) begin
        count <= count + QCW'(1);
      end else if (pop && !push) begin
        count <= count - QCW'(1);
      end
    end
  end

endmodule

FILE: hw/rtl/ant_engine.sv
// back end: table lookup, refresh or append, aging pass with running minimum
module ant_engine
  import ant_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  q_valid,
  output logic  q_ready,
  input  item_t q_item,
  output logic  res_valid,
  input  logic  res_ready,
  output res_t  res
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_UPDATE,
    ST_EV_RD,
    ST_EV_CHK,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_REPORT
  } state_t;

  state_t        state;
  item_t         item;
  logic [CW-1:0] fill;
  logic [AW-1:0] idx;
  logic [AW-1:0] slot;
  logic          is_new;
  logic          drop;
  logic [7:0]    min_dist;

  logic [CW-1:0]    fill_m1;
  logic [CW-1:0]    fill_p1;
  logic [AW-1:0]    last_addr;
  logic             at_last;
  logic             full;
  logic [CW+4:0]    fill_ext;
  logic [31:0]      age;
  logic             old;

  logic               ram_wr_en;
  logic [AW-1:0]      ram_wr_addr;
  entry_t             ram_wr_data;
  logic               ram_rd_en;
  logic [AW-1:0]      ram_rd_addr;
  logic [ENTRY_W-1:0] ram_rd_raw;
  entry_t             rd_entry;

  assign fill_m1   = fill - CW'(1);
  assign fill_p1   = fill + CW'(1);
  assign last_addr = fill_m1[AW-1:0];
  assign at_last   = (idx == last_addr);
  assign full      = (fill == CW'(TABLE_DEPTH));
  assign fill_ext  = {5'b0, fill};
  assign rd_entry  = entry_t'(ram_rd_raw);
  assign age       = item.now - rd_entry.tick;
  assign old       = (age > {16'b0, cfg.max_age});
  assign q_ready   = (state == ST_IDLE);

  assign ram_rd_en   = (state == ST_SCAN_RD) || (state == ST_EV_RD) || (state == ST_MOVE_RD);
  assign ram_rd_addr = (state == ST_MOVE_RD) ? last_addr : idx;
  assign ram_wr_en   = ((state == ST_UPDATE) && !drop) || (state == ST_MOVE_WR);
  assign ram_wr_addr = (state == ST_UPDATE) ? slot : idx;

  always_comb begin
    if (state == ST_UPDATE) begin
      ram_wr_data.id       = item.sender_id;
      ram_wr_data.tick     = item.now;
      ram_wr_data.distance = item.msg_distance;
    end else begin
      ram_wr_data = rd_entry;
    end
  end

  ant_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_raw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      res_valid <= 1'b0;
    end else begin
      // the report state drives valid on its own
      if (res_valid && res_ready && (state != ST_REPORT)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            item     <= q_item;
            drop     <= 1'b0;
            min_dist <= DIST_EMPTY;
            if (q_item.msg_valid) begin
              idx <= '0;
              if (fill == '0) begin
                slot   <= '0;
                is_new <= 1'b1;
                state  <= ST_UPDATE;
              end else begin
                state <= ST_SCAN_RD;
              end
            end else if (fill == '0) begin
              state <= ST_REPORT;
            end else begin
              idx   <= last_addr;
              state <= ST_EV_RD;
            end
          end
        end
        ST_SCAN_RD: begin
          state <= ST_SCAN_CHK;
        end
        ST_SCAN_CHK: begin
          if (rd_entry.id == item.sender_id) begin
            slot   <= idx;
            is_new <= 1'b0;
            state  <= ST_UPDATE;
          end else if (at_last) begin
            if (!full) begin
              slot   <= fill[AW-1:0];
              is_new <= 1'b1;
              state  <= ST_UPDATE;
            end else begin
              drop  <= 1'b1;
              idx   <= last_addr;
              state <= ST_EV_RD;
            end
          end else begin
            idx   <= idx + AW'(1);
            state <= ST_SCAN_RD;
          end
        end
        ST_UPDATE: begin
          if (is_new) begin
            fill <= fill_p1;
            idx  <= fill[AW-1:0];
          end else begin
            idx <= last_addr;
          end
          state <= ST_EV_RD;
        end
        ST_EV_RD: begin
          state <= ST_EV_CHK;
        end
        ST_EV_CHK: begin
          if (old && !at_last) begin
            state <= ST_MOVE_RD;
          end else begin
            if (old) begin
              fill <= fill_m1;
            end else if (rd_entry.distance < min_dist) begin
              min_dist <= rd_entry.distance;
            end
            if (idx == '0) begin
              state <= ST_REPORT;
            end else begin
              idx   <= idx - AW'(1);
              state <= ST_EV_RD;
            end
          end
        end
        ST_MOVE_RD: begin
          state <= ST_MOVE_WR;
        end
        ST_MOVE_WR: begin
          fill <= fill_m1;
          if (idx == '0) begin
            state <= ST_REPORT;
          end else begin
            idx   <= idx - AW'(1);
            state <= ST_EV_RD;
          end
        end
        ST_REPORT: begin
          if (!res_valid || res_ready) begin
            res.neighbour_count  <= fill_ext[4:0];
            res.closest_distance <= min_dist;
            res.too_close        <= (fill != '0) && (min_dist <= cfg.near_limit);
            res.dropped          <= drop;
            res_valid            <= 1'b1;
            state                <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/aging_neighbour_table.sv
// top level of the aging neighbour table
// usage
//   input channel: in_valid/in_ready with msg_valid, sender_id, msg_distance
//   and now; one beat per tick, msg_valid marks a received message
//   output channel: out_valid/out_ready, exactly one result beat per input
//   beat, in order: neighbour_count, closest_distance, too_close, dropped
//   config channel: cfg_valid/cfg_ready (always ready), cfg_index selects
//   max_age (0) or near_limit (1); other indexes are ignored; write only
//   while the block is idle
// latency and throughput
//   one cycle to take the beat, 2 per entry compared in the id lookup, one
//   for the table write, 2 per entry in the aging pass, 2 more per eviction
//   that moves the last entry, one for the report: at most 6*N + 1 cycles
//   with N entries, 97 for sixteen, 2 with an empty table and no message,
//   plus one cycle in the input queue; the single table ram port sets this
// reset
//   synchronous rst empties the table (count to zero), flushes the input
//   queue and the output register; config returns to 64 and 50
// stalls
//   a two-beat input queue keeps taking beats; a held result stalls the engine
module aging_neighbour_table
  import ant_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // input beats
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  msg_valid,
  input  logic [7:0]            sender_id,
  input  logic [7:0]            msg_distance,
  input  logic [31:0]           now,
  // result beats
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [4:0]            neighbour_count,
  output logic [7:0]            closest_distance,
  output logic                  too_close,
  output logic                  dropped,
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t  cfg;
  item_t in_item;
  item_t q_item;
  logic  q_valid;
  logic  q_ready;
  res_t  res;

  // config registers, writes never stall
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_age    <= MAX_AGE_RST;
      cfg.near_limit <= NEAR_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAX_AGE:    cfg.max_age    <= cfg_data;
        CFG_NEAR_LIMIT: cfg.near_limit <= cfg_data[7:0];
        default: begin
          // unknown index, write dropped
        end
      endcase
    end
  end

  // pack the input beat
  assign in_item.msg_valid    = msg_valid;
  assign in_item.sender_id    = sender_id;
  assign in_item.msg_distance = msg_distance;
  assign in_item.now          = now;

  // front: input queue
  ant_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  // back: table sequencer and output register
  ant_engine #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res)
  );

  // unpack the result beat
  assign neighbour_count  = res.neighbour_count;
  assign closest_distance = res.closest_distance;
  assign too_close        = res.too_close;
  assign dropped          = res.dropped;

endmodule

FILE: hw/rtl/ant_checker.sv
// port-level checks for the aging neighbour table, bound to the top level
module ant_checker
  import ant_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  msg_valid,
  input logic [7:0]            sender_id,
  input logic [7:0]            msg_distance,
  input logic [31:0]           now,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [4:0]            neighbour_count,
  input logic [7:0]            closest_distance,
  input logic                  too_close,
  input logic                  dropped
);

  // waiting input beat stays put
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(msg_valid) && $stable(sender_id)
      && $stable(msg_distance) && $stable(now))
    else $error("input beat changed while waiting");

  // held result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(neighbour_count)
      && $stable(closest_distance) && $stable(too_close) && $stable(dropped))
    else $error("result beat changed while stalled");

  // too close needs at least one neighbour
  a_close_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid && too_close |-> neighbour_count != 5'd0)
    else $error("too_close raised on an empty table");

  // empty table reports the empty distance
  a_empty_dist: assert property (@(posedge clk) disable iff (rst)
    out_valid && neighbour_count == 5'd0 |-> closest_distance == DIST_EMPTY)
    else $error("empty table with a real distance");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result beat right after reset");

endmodule

bind aging_neighbour_table ant_checker u_ant_checker (.*);
